### rtl/core/positional_insert_delete_list_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional insert/delete list
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH

// Same-cycle implication
`define PIDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PIDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pidl_pkg.sv
// ---------------------------------------------------------------------------
// pidl_pkg
// Types, sizes and codes shared by the positional insert/delete list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    // positions run up to DEPTH+1 (append to a full list), counts up to DEPTH
    localparam int POS_W      = $clog2(DEPTH + 2);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_TRAVERSE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic [POS_W-1:0]              position;
        logic signed [DATA_WIDTH-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic signed [DATA_WIDTH-1:0]  data;
        logic [CNT_W-1:0]              index;
        logic [CNT_W-1:0]              count;
        logic                          last;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        cell_op_t                      op;
        logic [IDX_W-1:0]              pos_idx;
        logic [IDX_W-1:0]              last_idx;
        logic signed [DATA_WIDTH-1:0]  value;
        logic signed [DATA_WIDTH-1:0]  head;
    } cell_cmd_t;

endpackage

### rtl/core/positional_insert_delete_list_top.sv
// ---------------------------------------------------------------------------
// positional_insert_delete_list_top
// Bounded ordered list of signed words held in a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (req_type, position, value)
//  result  | rsp_valid | rsp_stall | rsp (status, data, index, count, last)
//
//  Insert, delete and rejected requests: one registered result each.
//  Traverse: one result per entry; the row rotates one place per result and
//  is back in order after the last one. An empty traverse gives one result.
//  Reset clears the entry count and the handshake; cell words are unset.
//  A stalled result holds; no request is taken until the result register
//  is free or being taken in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_list_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pidl_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pidl_pkg::rsp_t    rsp
);

    typedef enum logic {
        S_IDLE,
        S_TRAV
    } state_t;

    state_t                              state_reg, state_next;
    logic [pidl_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [pidl_pkg::IDX_W-1:0]          trav_reg, trav_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    pidl_pkg::rsp_t                      rsp_reg, rsp_next;

    pidl_pkg::cell_cmd_t                 cmd;
    logic signed [pidl_pkg::DATA_WIDTH-1:0] q   [pidl_pkg::DEPTH];
    logic signed [pidl_pkg::DATA_WIDTH-1:0] rd  [pidl_pkg::DEPTH];
    logic signed [pidl_pkg::DATA_WIDTH-1:0] removed;

    logic                                out_free;
    logic                                accept;
    logic [pidl_pkg::CNT_W:0]            pos_ext;
    logic [pidl_pkg::CNT_W:0]            cnt_ext;
    logic [pidl_pkg::CNT_W-1:0]          trav_pos;
    logic                                trav_last;

    genvar g;
    generate
        for (g = 0; g < pidl_pkg::DEPTH; g++)
        begin : g_cell
            logic signed [pidl_pkg::DATA_WIDTH-1:0] left_w;
            logic signed [pidl_pkg::DATA_WIDTH-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = q[g-1];
            end

            if (g == pidl_pkg::DEPTH - 1)
            begin : g_tail
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = q[g+1];
            end

            pidl_cell u_cell (
                .clk      (clk),
                .cell_idx (pidl_pkg::IDX_W'(g)),
                .cmd      (cmd),
                .left     (left_w),
                .right    (right_w),
                .q        (q[g]),
                .rd       (rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < pidl_pkg::DEPTH; i++)
        begin
            removed = removed | rd[i];
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    assign pos_ext   = {1'b0, req.position};
    assign cnt_ext   = {1'b0, count_reg};
    assign trav_pos  = pidl_pkg::CNT_W'(trav_reg) + pidl_pkg::CNT_W'(1);
    assign trav_last = (trav_pos == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        trav_next      = trav_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        cmd.op       = pidl_pkg::OP_HOLD;
        cmd.pos_idx  = pidl_pkg::IDX_W'(req.position - pidl_pkg::POS_W'(1));
        cmd.last_idx = pidl_pkg::IDX_W'(count_reg - pidl_pkg::CNT_W'(1));
        cmd.value    = req.value;
        cmd.head     = q[0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status = pidl_pkg::ST_BADPOS;
                    rsp_next.data   = '0;
                    rsp_next.index  = '0;
                    rsp_next.count  = count_reg;
                    rsp_next.last   = 1'b1;
                    rsp_valid_next  = 1'b1;
                    case (req.req_type)
                        pidl_pkg::REQ_INSERT:
                        begin
                            if (req.position != '0 && pos_ext <= cnt_ext + 1'b1)
                            begin
                                if (count_reg >= pidl_pkg::CNT_W'(pidl_pkg::DEPTH))
                                begin
                                    rsp_next.status = pidl_pkg::ST_FULL;
                                end
                                else
                                begin
                                    cmd.op          = pidl_pkg::OP_INSERT;
                                    count_next      = count_reg + 1'b1;
                                    rsp_next.count  = count_reg + 1'b1;
                                    rsp_next.status = pidl_pkg::ST_OK;
                                end
                            end
                        end
                        pidl_pkg::REQ_DELETE:
                        begin
                            if (req.position != '0 && pos_ext <= cnt_ext)
                            begin
                                cmd.op          = pidl_pkg::OP_DELETE;
                                count_next      = count_reg - 1'b1;
                                rsp_next.count  = count_reg - 1'b1;
                                rsp_next.status = pidl_pkg::ST_OK;
                                rsp_next.data   = removed;
                            end
                        end
                        pidl_pkg::REQ_TRAVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = pidl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // results come from the rotating row
                                rsp_valid_next = 1'b0;
                                trav_next      = '0;
                                state_next     = S_TRAV;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = pidl_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end
            S_TRAV:
            begin
                if (out_free)
                begin
                    cmd.op          = pidl_pkg::OP_ROTATE;
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = pidl_pkg::ST_OK;
                    rsp_next.data   = q[0];
                    rsp_next.index  = trav_pos;
                    rsp_next.count  = count_reg;
                    rsp_next.last   = trav_last;
                    trav_next       = trav_reg + 1'b1;
                    if (trav_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            trav_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            trav_reg      <= trav_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/core/pidl_cell.sv
// ---------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word and shifts it to or from its neighbours.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidl_cell (
    input  logic                                  clk,
    input  logic [pidl_pkg::IDX_W-1:0]            cell_idx,
    input  pidl_pkg::cell_cmd_t                   cmd,
    input  logic signed [pidl_pkg::DATA_WIDTH-1:0] left,
    input  logic signed [pidl_pkg::DATA_WIDTH-1:0] right,
    output logic signed [pidl_pkg::DATA_WIDTH-1:0] q,
    output logic signed [pidl_pkg::DATA_WIDTH-1:0] rd
);

    logic signed [pidl_pkg::DATA_WIDTH-1:0] word_reg;
    logic signed [pidl_pkg::DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            pidl_pkg::OP_INSERT:
            begin
                if (cell_idx == cmd.pos_idx)
                begin
                    word_next = cmd.value;
                end
                else if (cell_idx > cmd.pos_idx)
                begin
                    word_next = left;
                end
            end
            pidl_pkg::OP_DELETE:
            begin
                if (cell_idx >= cmd.pos_idx)
                begin
                    word_next = right;
                end
            end
            pidl_pkg::OP_ROTATE:
            begin
                // wrap the head round to the tail of the stored part
                word_next = (cell_idx == cmd.last_idx) ? cmd.head : right;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q  = word_reg;
    assign rd = (cell_idx == cmd.pos_idx) ? word_reg : '0;

endmodule

### rtl/core/pidl_checker.sv
// ---------------------------------------------------------------------------
// pidl_checker
// Port-level checks on the result stream of the list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_insert_delete_list_top_macros.svh"

module pidl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  pidl_pkg::req_t    req,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  pidl_pkg::rsp_t    rsp
);

    logic req_take;
    logic rsp_wait;
    logic rsp_mid;
    logic rsp_ok;
    logic rsp_reject;
    logic single_shape;
    logic single_done;

    assign req_take     = req_valid && !req_stall && (req.req_type != pidl_pkg::REQ_TRAVERSE);
    assign rsp_wait     = rsp_valid && rsp_stall;
    assign rsp_mid      = rsp_valid && !rsp.last;
    assign rsp_ok       = (rsp.status == pidl_pkg::ST_OK);
    assign rsp_reject   = rsp_valid && !rsp_ok;
    assign single_shape = rsp.last && (rsp.index == '0);
    assign single_done  = rsp_valid && single_shape;

    `PIDL_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid, "result dropped while stalled")
    `PIDL_ASSERT_NOW(a_mid_ok, rsp_mid, rsp_ok, "non-final result not ok")
    `PIDL_ASSERT_NOW(a_reject_shape, rsp_reject, single_shape, "rejected result malformed")
    `PIDL_ASSERT_NOW(a_index_range, rsp_valid, rsp.index <= rsp.count, "index beyond count")
    `PIDL_ASSERT_NEXT(a_single_result, req_take, single_done, "no single final result")

endmodule

bind positional_insert_delete_list_top pidl_checker u_pidl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
